@@ rtl/tamg_pkg.sv @@
`default_nettype none

package tamg_pkg;

    // sizes
    localparam int MAX_CONTEXT = 1024;
    localparam int MAX_ROWS    = 64;
    localparam int WORD_BITS   = 64;
    localparam int MAX_WORDS   = (MAX_CONTEXT + WORD_BITS - 1) / WORD_BITS;

    localparam int BIT_W   = $clog2(WORD_BITS);          // bit within a word
    localparam int WIDX_W  = $clog2(MAX_WORDS);          // word within a row
    localparam int ROW_W   = $clog2(MAX_ROWS);           // row index
    localparam int ADDR_W  = ROW_W + WIDX_W;             // row store address
    localparam int CTX_W   = 11;                         // column count register
    localparam int ROWS_W  = 7;                          // rows_in_batch register
    localparam int PAST_W  = 11;                         // past_count register
    localparam int WIN_W   = 13;                         // window_size register
    localparam int PAR_W   = 7;                          // parent_row field
    localparam int OFS_W   = 10;                         // token position field
    localparam int COL_W   = $clog2(MAX_CONTEXT);        // column index
    localparam int NW_W    = WIDX_W + 1;                 // word count 1..MAX_WORDS
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // stream widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 80;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONTEXT_LEN   = 3'd0,
        REG_ROWS_IN_BATCH = 3'd1,
        REG_PAST_COUNT    = 3'd2,
        REG_WINDOW_ENABLE = 3'd3,
        REG_WINDOW_SIZE   = 3'd4,
        REG_USE_OFFSETS   = 3'd5
    } cfg_reg_t;

    // per-row parameters, fixed when the item is accepted
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  parent;
        logic              src_mem;     // copy parent row from the store
        logic              past_fill;   // negative parent: fill past columns
        logic              not_ready;
        logic [NW_W-1:0]   words;
        logic [CTX_W-1:0]  ctx;
        logic [CTX_W-1:0]  n_past;
        logic [CTX_W-1:0]  n_clr;
        logic [COL_W-1:0]  col;
        logic              col_vld;
    } row_param_t;

    // ones for every column of word widx that lies below limit
    function automatic logic [WORD_BITS-1:0] therm_word(
        input logic [CTX_W-1:0]  limit,
        input logic [WIDX_W-1:0] widx
    );
        logic signed [CTX_W+1:0] diff;
        logic [WORD_BITS-1:0]    res;
        diff = $signed({2'b00, limit})
             - $signed({{(CTX_W+2-WIDX_W-BIT_W){1'b0}}, widx, {BIT_W{1'b0}}});
        if (diff <= 0)
            res = '0;
        else if (diff >= WORD_BITS)
            res = '1;
        else
            res = ~({WORD_BITS{1'b1}} << diff[BIT_W-1:0]);
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tamg_row_ram.sv @@
`default_nettype none

module tamg_row_ram
    import tamg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_W-1:0]    waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_W-1:0]    raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [MAX_ROWS*MAX_WORDS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tamg_word_calc.sv @@
`default_nettype none

module tamg_word_calc
    import tamg_pkg::*;
(
    input  wire row_param_t           prm,
    input  wire logic [WIDX_W-1:0]    widx,
    input  wire logic [WORD_BITS-1:0] parent_word,
    output logic      [WORD_BITS-1:0] word
);

    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] own_bit;
    logic [WORD_BITS-1:0] clr_mask;
    logic [WORD_BITS-1:0] ctx_mask;

    // starting contents: parent copy, past fill or zeros
    always_comb
    begin
        if (prm.src_mem)
            base = parent_word;
        else if (prm.past_fill)
            base = therm_word(prm.n_past, widx);
        else
            base = '0;
    end

    // own column, window clear and columns beyond the context
    always_comb
    begin
        own_bit = '0;
        if (prm.col_vld && (prm.col[COL_W-1:BIT_W] == widx))
            own_bit = {{(WORD_BITS-1){1'b0}}, 1'b1} << prm.col[BIT_W-1:0];
        clr_mask = therm_word(prm.n_clr, widx);
        ctx_mask = therm_word(prm.ctx, widx);
        word     = (base | own_bit) & ~clr_mask & ctx_mask;
    end

endmodule

`default_nettype wire

@@ rtl/tree_attention_mask_generator_top.sv @@
// channel   | dir | signals                 | contents (low bits first)
// s         | in  | tvalid tready tdata     | parent_row[6:0], token_pos[16:7]
// m         | out | tvalid tready tdata     | mask_word[63:0], row_number[69:64],
//           |     | tuser tlast             |   word_number[73:70]; tuser parent_not_ready
// cfg       | in  | cfg_we cfg_index cfg_data | register write, no read-back
//
// One item gives ceil(column count/64) words; the row store has one read port,
// so an item's words are read one by one and the next item waits for its last write.
// Reset loads the config defaults, clears the row counter and all valid flags;
// the row store is not cleared, a row is written before any later row can read it.
// A stall on m holds the word pipe; s is ready only between rows.
`default_nettype none

module tree_attention_mask_generator_top
    import tamg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // parent_row, token_pos
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,   // mask_word, row_number, word_number
    output logic      [0:0]            m_tuser,   // parent_not_ready
    output logic                       m_tlast,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [CTX_W-1:0]  col_count_reg;
    logic [ROWS_W-1:0] rows_in_batch_reg;
    logic [PAST_W-1:0] past_count_reg;
    logic              window_enable_reg;
    logic [WIN_W-1:0]  window_size_reg;
    logic              use_offsets_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg     <= CTX_W'(MAX_CONTEXT);
            rows_in_batch_reg <= ROWS_W'(1);
            past_count_reg    <= '0;
            window_enable_reg <= 1'b0;
            window_size_reg   <= WIN_W'(1024);
            use_offsets_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONTEXT_LEN:   col_count_reg     <= cfg_data[CTX_W-1:0];
                REG_ROWS_IN_BATCH: rows_in_batch_reg <= cfg_data[ROWS_W-1:0];
                REG_PAST_COUNT:    past_count_reg    <= cfg_data[PAST_W-1:0];
                REG_WINDOW_ENABLE: window_enable_reg <= cfg_data[0];
                REG_WINDOW_SIZE:   window_size_reg   <= cfg_data[WIN_W-1:0];
                REG_USE_OFFSETS:   use_offsets_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer state
    logic              busy_reg;
    logic [NW_W-1:0]   rd_w_reg;
    logic              s2_vld_reg;
    logic [WIDX_W-1:0] s2_w_reg;
    row_param_t        prm_reg;
    row_param_t        prm_next;
    logic [ROW_W-1:0]  row_counter_reg;
    logic [ROW_W-1:0]  row_counter_next;

    logic accept;
    logic out_free;
    logic fire2;
    logic issue;

    assign s_tready = !busy_reg && !s2_vld_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;
    assign fire2    = s2_vld_reg && out_free;
    assign issue    = busy_reg && (!s2_vld_reg || fire2);

    // row parameters from config and the incoming item
    logic [CTX_W-1:0]        ctx_c;
    logic [ROWS_W-1:0]       ar_c;
    logic [ROW_W-1:0]        r_c;
    logic [ROWS_W-1:0]       r_inc;
    logic [PAR_W-1:0]        parent_in;
    logic [OFS_W-1:0]        offset_in;
    logic [OFS_W-1:0]        offset_sel;
    logic [CTX_W:0]          words_sum;
    logic signed [CTX_W+1:0] col_s;
    logic signed [14:0]      clr_s;

    always_comb
    begin
        parent_in = s_tdata[PAR_W-1:0];
        offset_in = s_tdata[PAR_W+OFS_W-1:PAR_W];

        if (col_count_reg == '0)
            ctx_c = CTX_W'(1);
        else if (col_count_reg > CTX_W'(MAX_CONTEXT))
            ctx_c = CTX_W'(MAX_CONTEXT);
        else
            ctx_c = col_count_reg;

        if (rows_in_batch_reg == '0)
            ar_c = ROWS_W'(1);
        else if (rows_in_batch_reg > ROWS_W'(MAX_ROWS))
            ar_c = ROWS_W'(MAX_ROWS);
        else
            ar_c = rows_in_batch_reg;

        r_c = ({1'b0, row_counter_reg} >= ar_c) ? '0 : row_counter_reg;
        r_inc = {1'b0, r_c} + ROWS_W'(1);
        row_counter_next = (r_inc >= ar_c) ? '0 : r_inc[ROW_W-1:0];

        words_sum = {1'b0, ctx_c} + (CTX_W+1)'(WORD_BITS - 1);

        prm_next.row       = r_c;
        prm_next.parent    = parent_in[ROW_W-1:0];
        prm_next.past_fill = parent_in[PAR_W-1];
        prm_next.src_mem   = !parent_in[PAR_W-1] && (parent_in[ROW_W-1:0] < r_c);
        prm_next.not_ready = !parent_in[PAR_W-1] && !(parent_in[ROW_W-1:0] < r_c);
        prm_next.words     = words_sum[BIT_W+NW_W-1:BIT_W];
        prm_next.ctx       = ctx_c;
        prm_next.n_past    = (past_count_reg > ctx_c) ? ctx_c : past_count_reg;

        // own column: ctx - rows + row, may be negative
        col_s = $signed({2'b00, ctx_c}) - $signed({6'b0, ar_c}) + $signed({7'b0, r_c});
        prm_next.col_vld = (col_s >= 0);
        prm_next.col     = col_s[COL_W-1:0];

        // window clear count: 2*past + offset + 1 - window
        offset_sel = use_offsets_reg ? offset_in : {{(OFS_W-ROW_W){1'b0}}, r_c};
        clr_s = $signed({3'b000, past_count_reg, 1'b0})
              + $signed({5'b0, offset_sel})
              + 15'sd1
              - $signed({2'b00, window_size_reg});
        if (!window_enable_reg || clr_s <= 0)
            prm_next.n_clr = '0;
        else if (clr_s > $signed({4'b0, ctx_c}))
            prm_next.n_clr = ctx_c;
        else
            prm_next.n_clr = clr_s[CTX_W-1:0];
    end

    // word sequencer: read parent word, then build and write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            rd_w_reg        <= '0;
            s2_vld_reg      <= 1'b0;
            row_counter_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg        <= 1'b1;
                rd_w_reg        <= '0;
                row_counter_reg <= row_counter_next;
            end
            else if (issue)
            begin
                rd_w_reg <= rd_w_reg + NW_W'(1);
                if (rd_w_reg + NW_W'(1) == prm_reg.words)
                    busy_reg <= 1'b0;
            end

            if (issue)
                s2_vld_reg <= 1'b1;
            else if (fire2)
                s2_vld_reg <= 1'b0;
        end
    end

    // item parameters and word index of the read in flight
    always_ff @(posedge clk)
    begin
        if (accept)
            prm_reg <= prm_next;
        if (issue)
            s2_w_reg <= rd_w_reg[WIDX_W-1:0];
    end

    // row store
    logic [WORD_BITS-1:0] parent_word;
    logic [WORD_BITS-1:0] word;

    tamg_row_ram u_ram (
        .clk   (clk),
        .we    (fire2),
        .waddr ({prm_reg.row, s2_w_reg}),
        .wdata (word),
        .re    (issue),
        .raddr ({prm_reg.parent, rd_w_reg[WIDX_W-1:0]}),
        .rdata (parent_word)
    );

    tamg_word_calc u_calc (
        .prm         (prm_reg),
        .widx        (s2_w_reg),
        .parent_word (parent_word),
        .word        (word)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (fire2)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire2)
        begin
            m_tdata    <= {6'b0, s2_w_reg, prm_reg.row, word};
            m_tuser[0] <= prm_reg.not_ready;
            m_tlast    <= ({1'b0, s2_w_reg} + NW_W'(1) == prm_reg.words);
        end
    end

`ifndef ASSERT_OFF
    // no new item while a row is still in the word pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg || s2_vld_reg) |-> !s_tready)
        else $error("item accepted while row in progress");

    // the read pointer never passes the row length
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rd_w_reg < prm_reg.words))
        else $error("word read pointer out of range");

    // a parent row is never the row being written
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire2 && prm_reg.src_mem) |-> (prm_reg.parent != prm_reg.row))
        else $error("parent row equals current row");
`endif

endmodule

`default_nettype wire

@@ tb/tb_tree_attention_mask_generator_top.sv @@
`timescale 1ns / 1ps

module tb_tree_attention_mask_generator_top
    import tamg_pkg::*;
;

    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 4;     // settle time after the last word
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 20;

    // one expected mask word
    typedef struct packed {
        logic [63:0] mask;
        logic [5:0]  row;
        logic [3:0]  word;
        logic        not_ready;
        logic        last;
    } mask_word_t;

    // one row of the directed table: a register write or an item
    typedef struct packed {
        logic        is_write;
        cfg_reg_t    reg_idx;
        logic [12:0] value;
        logic [6:0]  parent;
        logic [9:0]  offset;
        logic        typed;       // last word given by hand
        logic [63:0] last_mask;
        logic        not_ready;
    } mask_step_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;   // parent_row, token_pos
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // mask_word, row_number, word_number
    logic [0:0]            m_tuser;          // parent_not_ready
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_CONTEXT_LEN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mirror of the block's registers and row state
    int          cfg_context  = 1024;
    int          cfg_rows     = 1;
    int          cfg_past     = 0;
    int          cfg_win_en   = 0;
    int          cfg_win_size = 1024;
    int          cfg_use_ofs  = 0;
    int          next_row_idx = 0;
    logic [63:0] built_rows [64][16];

    mask_word_t  pending_words [$];
    mask_step_t  directed_plan [$];

    int tx_idle_pct    = 25;
    int rx_idle_pct    = 60;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int items_sent     = 0;
    int words_seen     = 0;
    int writes_done    = 0;

    tree_attention_mask_generator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // effective context length and batch size after clamping
    function automatic int ctx_cols(input int raw);
        if (raw < 1)
            return 1;
        if (raw > MAX_CONTEXT)
            return MAX_CONTEXT;
        return raw;
    endfunction

    function automatic int batch_rows();
        if (cfg_rows < 1)
            return 1;
        if (cfg_rows > MAX_ROWS)
            return MAX_ROWS;
        return cfg_rows;
    endfunction

    function automatic int current_row();
        return (next_row_idx >= batch_rows()) ? 0 : next_row_idx;
    endfunction

    // mostly valid parents (past-only or an already built row), some noise
    function automatic logic [6:0] pick_parent(input int r);
        int sel;
        int p;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            if (r > 0 && $urandom_range(0, 3) != 0)
                p = $urandom_range(0, r - 1);
            else
                p = -1 - int'($urandom_range(0, 63));
        end
        else if (sel < 85)
            p = int'($urandom_range(0, 127)) - 64;
        else
            p = $urandom_range(r, 63);
        return p[6:0];
    endfunction

    // build one mask row, store it and queue its words
    task automatic predict_mask_row(input logic signed [6:0] par, input logic [9:0] ofs);
        logic [63:0] row_bits [16];
        mask_word_t  mw;
        int          ctx, ar, r, n, col, words, parent, offset, i, w;
        logic        nr;
        ctx    = ctx_cols(cfg_context);
        ar     = batch_rows();
        r      = current_row();
        words  = (ctx + WORD_BITS - 1) / WORD_BITS;
        parent = par;
        nr     = 1'b0;
        for (w = 0; w < MAX_WORDS; w++)
            row_bits[w] = '0;

        // past fill, parent copy, or parent not built yet
        if (parent < 0) begin
            n = (cfg_past > ctx) ? ctx : cfg_past;
            for (i = 0; i < n; i++)
                row_bits[i / 64][i % 64] = 1'b1;
        end
        else if (parent < r) begin
            for (w = 0; w < MAX_WORDS; w++)
                row_bits[w] = built_rows[parent][w];
        end
        else
            nr = 1'b1;

        // own column
        col = ctx - ar + r;
        if (col >= 0 && col < ctx)
            row_bits[col / 64][col % 64] = 1'b1;

        // sliding window clears the oldest columns
        if (cfg_win_en != 0) begin
            offset = (cfg_use_ofs != 0) ? int'(ofs) : r;
            n = 2 * cfg_past + offset + 1 - cfg_win_size;
            if (n < 0)
                n = 0;
            if (n > ctx)
                n = ctx;
            for (i = 0; i < n; i++)
                row_bits[i / 64][i % 64] = 1'b0;
        end

        for (i = ctx; i < MAX_WORDS * WORD_BITS; i++)
            row_bits[i / 64][i % 64] = 1'b0;

        for (w = 0; w < MAX_WORDS; w++)
            built_rows[r][w] = row_bits[w];

        for (w = 0; w < words; w++) begin
            mw.mask      = row_bits[w];
            mw.row       = r[5:0];
            mw.word      = w[3:0];
            mw.not_ready = nr;
            mw.last      = (w == words - 1);
            pending_words.push_back(mw);
        end

        r++;
        if (r >= ar)
            r = 0;
        next_row_idx = r;
    endtask

    // offer one item, wait for the handshake, then predict it
    task automatic send_item(input logic [6:0] par, input logic [9:0] ofs);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {7'd0, ofs, par};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict_mask_row(par, ofs);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write while idle; a context raise mid-batch first completes the batch
    task automatic set_reg(input cfg_reg_t idx, input int val);
        int  raw;
        raw = val;
        if (idx == REG_CONTEXT_LEN && current_row() != 0
            && ctx_cols(raw & 'h7FF) > ctx_cols(cfg_context)) begin
            while (current_row() != 0)
                send_item(pick_parent(current_row()), 10'($urandom_range(0, 1023)));
        end
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= raw[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_CONTEXT_LEN:   cfg_context  = raw & 'h7FF;
            REG_ROWS_IN_BATCH: cfg_rows     = raw & 'h7F;
            REG_PAST_COUNT:    cfg_past     = raw & 'h7FF;
            REG_WINDOW_ENABLE: cfg_win_en   = raw & 'h1;
            REG_WINDOW_SIZE:   cfg_win_size = raw & 'h1FFF;
            REG_USE_OFFSETS:   cfg_use_ofs  = raw & 'h1;
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic plan_write(input cfg_reg_t idx, input int val);
        mask_step_t st;
        st          = '0;
        st.is_write = 1'b1;
        st.reg_idx  = idx;
        st.value    = val[12:0];
        directed_plan.push_back(st);
    endtask

    task automatic plan_item(input int par, input int ofs, input logic typed,
                             input logic [63:0] last_mask, input logic nr);
        mask_step_t st;
        st           = '0;
        st.reg_idx   = REG_CONTEXT_LEN;
        st.parent    = par[6:0];
        st.offset    = ofs[9:0];
        st.typed     = typed;
        st.last_mask = last_mask;
        st.not_ready = nr;
        directed_plan.push_back(st);
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (mismatch_count < 10)
            $display("mismatch %s: expected %h actual %h", field, exp_v, act_v);
        mismatch_count++;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // compare every accepted word with the oldest expectation
    always @(posedge clk) begin
        mask_word_t mw;
        if (rst_n && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_words.size() == 0)
                note_mismatch("unexpected word", '0, m_tdata[63:0]);
            else begin
                mw = pending_words.pop_front();
                if (m_tdata[63:0] !== mw.mask)
                    note_mismatch("mask_word", mw.mask, m_tdata[63:0]);
                if (m_tdata[69:64] !== mw.row)
                    note_mismatch("row_number", 64'(mw.row), 64'(m_tdata[69:64]));
                if (m_tdata[73:70] !== mw.word)
                    note_mismatch("word_number", 64'(mw.word), 64'(m_tdata[73:70]));
                if (m_tuser[0] !== mw.not_ready)
                    note_mismatch("parent_not_ready", 64'(mw.not_ready), 64'(m_tuser[0]));
                if (m_tlast !== mw.last)
                    note_mismatch("last_word", 64'(mw.last), 64'(m_tlast));
            end
        end
    end

    // run limit
    initial begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        mask_step_t st;
        mask_word_t mw;
        int         k, ph, it, rsel, ctx_v, past_v, rand_items;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, extremes, parent not ready, window, clamping
        plan_item(-1, 0, 1'b1, 64'h8000_0000_0000_0000, 1'b0);
        plan_item(0, 0, 1'b1, 64'h8000_0000_0000_0000, 1'b1);
        plan_write(REG_CONTEXT_LEN, 64);
        plan_write(REG_ROWS_IN_BATCH, 4);
        plan_write(REG_PAST_COUNT, 10);
        plan_item(-1, 0, 1'b1, 64'h1000_0000_0000_03FF, 1'b0);
        plan_item(0, 0, 1'b1, 64'h3000_0000_0000_03FF, 1'b0);
        plan_item(63, 0, 1'b1, 64'h4000_0000_0000_0000, 1'b1);
        plan_item(-64, 1023, 1'b1, 64'h8000_0000_0000_03FF, 1'b0);
        plan_write(REG_WINDOW_ENABLE, 1);
        plan_write(REG_WINDOW_SIZE, 1);
        plan_item(-1, 0, 1'b1, 64'h1000_0000_0000_0000, 1'b0);
        plan_item(0, 0, 1'b1, 64'h3000_0000_0000_0000, 1'b0);
        plan_write(REG_USE_OFFSETS, 1);
        plan_item(1, 0, 1'b1, 64'h7000_0000_0000_0000, 1'b0);
        plan_item(-1, 1023, 1'b1, 64'h0, 1'b0);
        // past count above the context, window too wide to clear anything
        plan_write(REG_WINDOW_SIZE, 4096);
        plan_write(REG_PAST_COUNT, 1024);
        plan_item(-1, 1023, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // context register above range clamps to the full row
        plan_write(REG_CONTEXT_LEN, 2047);
        plan_item(-1, 0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        plan_item(0, 0, 1'b0, 64'h0, 1'b0);
        // context of zero, batch above range: own column falls outside the row
        plan_write(REG_CONTEXT_LEN, 0);
        plan_write(REG_ROWS_IN_BATCH, 100);
        plan_write(REG_WINDOW_ENABLE, 0);
        plan_write(REG_PAST_COUNT, 2047);
        plan_item(-1, 0, 1'b1, 64'h1, 1'b0);
        plan_item(63, 1023, 1'b1, 64'h0, 1'b1);
        plan_write(REG_ROWS_IN_BATCH, 64);
        plan_write(REG_CONTEXT_LEN, 64);
        plan_item(3, 0, 1'b1, 64'h1, 1'b1);
        // single-row batch wraps the counter every item
        plan_write(REG_ROWS_IN_BATCH, 1);
        plan_write(REG_PAST_COUNT, 0);
        plan_write(REG_WINDOW_ENABLE, 1);
        plan_write(REG_WINDOW_SIZE, 1);
        plan_write(REG_USE_OFFSETS, 0);
        plan_item(-1, 0, 1'b1, 64'h8000_0000_0000_0000, 1'b0);

        for (k = 0; k < directed_plan.size(); k++) begin
            st = directed_plan[k];
            if (st.is_write)
                set_reg(st.reg_idx, int'(st.value));
            else begin
                send_item(st.parent, st.offset);
                if (st.typed) begin
                    mw = pending_words[pending_words.size() - 1];
                    mw.mask      = st.last_mask;
                    mw.not_ready = st.not_ready;
                    pending_words[pending_words.size() - 1] = mw;
                end
            end
        end

        // random settings, each followed by a run of items
        rand_items = 0;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            rsel = $urandom_range(0, 9);
            if (rsel == 0)
                ctx_v = 1024;
            else if (rsel == 1)
                case ($urandom_range(0, 3))
                    0: ctx_v = 0;
                    1: ctx_v = 64;
                    2: ctx_v = 2047;
                    default: ctx_v = 1023;
                endcase
            else
                ctx_v = $urandom_range(64, 320);
            set_reg(REG_CONTEXT_LEN, ctx_v);

            rsel = $urandom_range(0, 9);
            if (rsel == 0)
                case ($urandom_range(0, 3))
                    0: set_reg(REG_ROWS_IN_BATCH, 0);
                    1: set_reg(REG_ROWS_IN_BATCH, 64);
                    2: set_reg(REG_ROWS_IN_BATCH, 100);
                    default: set_reg(REG_ROWS_IN_BATCH, 127);
                endcase
            else if (rsel < 4)
                set_reg(REG_ROWS_IN_BATCH, $urandom_range(1, 64));
            else
                set_reg(REG_ROWS_IN_BATCH, $urandom_range(1, 16));

            rsel = $urandom_range(0, 9);
            if (rsel == 0)
                past_v = ($urandom_range(0, 1) != 0) ? 2047 : 1024;
            else if (rsel == 1)
                past_v = 0;
            else
                past_v = $urandom_range(0, ctx_cols(ctx_v));
            set_reg(REG_PAST_COUNT, past_v);

            set_reg(REG_WINDOW_ENABLE, $urandom_range(0, 1));

            // window size mostly near the point where clearing starts
            rsel = $urandom_range(0, 9);
            if (rsel == 0)
                set_reg(REG_WINDOW_SIZE, ($urandom_range(0, 1) != 0) ? 8191 : 1);
            else if (rsel < 3)
                set_reg(REG_WINDOW_SIZE, $urandom_range(1, 4096));
            else begin
                k = 2 * past_v + int'($urandom_range(0, 160)) - 40;
                if (k < 1)
                    k = 1;
                if (k > 8191)
                    k = 8191;
                set_reg(REG_WINDOW_SIZE, k);
            end

            set_reg(REG_USE_OFFSETS, $urandom_range(0, 1));

            for (it = 0; it < PHASE_ITEMS; it++) begin
                // idle mix by progress: sender light, then receiver light, then none
                if (rand_items < 80) begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 60;
                end
                else if (rand_items < 160) begin
                    tx_idle_pct = 60;
                    rx_idle_pct = 25;
                end
                else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if (rand_items == 40)
                    hold_requests = hold_requests + 1;
                if (rand_items == 120)
                    drain_results();
                send_item(pick_parent(current_row()), 10'($urandom_range(0, 1023)));
                rand_items++;
            end
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("run covered %0d items, %0d mask words, %0d register writes",
                 items_sent, words_seen, writes_done);
        $display("settings: %0d random phases plus directed clamping and window cases",
                 RAND_PHASES);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tamg_pkg.sv
rtl/tamg_row_ram.sv
rtl/tamg_word_calc.sv
rtl/tree_attention_mask_generator_top.sv
tb/tb_tree_attention_mask_generator_top.sv
